### rtl/core/lrs_pkg.sv
`timescale 1ns / 1ps

package lrs_pkg;

    localparam int BYTE_W    = 8;
    localparam int SBITS_W   = 4;
    localparam int MOD_W     = 14;
    localparam int WANT_W    = 9;
    localparam int COEF_W    = 13;
    localparam int IDX_W     = 8;
    localparam int RES_W     = 20;
    localparam int FILL_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 14;

    localparam logic [SBITS_W-1:0] SAMPLE_BITS_WIDE  = 4'd13;
    localparam logic [SBITS_W-1:0] SAMPLE_BITS_RESET = 4'd12;
    localparam logic [MOD_W-1:0]   MODULUS_RESET     = 14'd3329;
    localparam logic [WANT_W-1:0]  WANTED_RESET      = 9'd256;
    localparam logic [FILL_W-1:0]  FILL_MAX          = 5'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_BITS  = 2'd0,
        REG_MODULUS      = 2'd1,
        REG_WANTED_COUNT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SBITS_W-1:0] sample_bits;
        logic [MOD_W-1:0]   modulus;
        logic [WANT_W-1:0]  wanted_count;
    } cfg_t;

endpackage

### rtl/core/lrs_if.sv
`timescale 1ns / 1ps

interface lrs_byte_if;
    logic                       valid;
    logic                       ready;
    logic [lrs_pkg::BYTE_W-1:0] data_byte;
    logic                       new_buffer;
    logic                       new_poly;

    modport source (output valid, output data_byte, output new_buffer, output new_poly,
                    input ready);
    modport sink (input valid, input data_byte, input new_buffer, input new_poly,
                  output ready);
endinterface

interface lrs_coeff_if;
    logic                       valid;
    logic                       ready;
    logic [lrs_pkg::COEF_W-1:0] coefficient;
    logic [lrs_pkg::IDX_W-1:0]  coeff_index;
    logic                       last;

    modport source (output valid, output coefficient, output coeff_index, output last,
                    input ready);
    modport sink (input valid, input coefficient, input coeff_index, input last,
                  output ready);
endinterface

interface lrs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lrs_pkg::CFG_IDX_W-1:0] addr;
    logic [lrs_pkg::CFG_DAT_W-1:0] wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink (input valid, input addr, input wdata, output ready);
endinterface

### rtl/core/lrs_cfg_regs.sv
`timescale 1ns / 1ps

module lrs_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    lrs_cfg_if.sink         cfg,
    output lrs_pkg::cfg_t   cfg_out
);
    import lrs_pkg::*;

    logic [SBITS_W-1:0] sample_bits_reg;
    logic [MOD_W-1:0]   modulus_reg;
    logic [WANT_W-1:0]  wanted_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bits_reg <= SAMPLE_BITS_RESET;
            modulus_reg     <= MODULUS_RESET;
            wanted_reg      <= WANTED_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.addr))
                REG_SAMPLE_BITS:  sample_bits_reg <= cfg.wdata[SBITS_W-1:0];
                REG_MODULUS:      modulus_reg     <= cfg.wdata[MOD_W-1:0];
                REG_WANTED_COUNT: wanted_reg      <= cfg.wdata[WANT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_out.sample_bits  = sample_bits_reg;
    assign cfg_out.modulus      = modulus_reg;
    assign cfg_out.wanted_count = wanted_reg;

endmodule

### rtl/core/lrs_core.sv
`timescale 1ns / 1ps

module lrs_core #(
    parameter int MAX_COUNT = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lrs_pkg::cfg_t cfg,
    lrs_byte_if.sink      src,
    lrs_coeff_if.source   coeff
);
    import lrs_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_COUNT + 1);
    localparam int CNT_W    = (CNT_BITS < WANT_W) ? CNT_BITS : WANT_W;

    // Input register.
    logic              in_vld_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              buf_mark_reg;
    logic              poly_mark_reg;

    // Sampler state.
    logic [RES_W-1:0]  res_reg;
    logic [RES_W-1:0]  res_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    // Result register.
    logic              out_vld_reg;
    logic [COEF_W-1:0] coef_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              last_reg;

    logic              advance;
    logic              wide;
    logic [CNT_W-1:0]  target;
    logic [CNT_W-1:0]  cnt0;
    logic [RES_W-1:0]  res0;
    logic [FILL_W-1:0] fill0;
    logic              done;
    logic [RES_W-1:0]  res1;
    logic [FILL_W-1:0] fill1;
    logic [FILL_W-1:0] width;
    logic              take;
    logic [COEF_W-1:0] cand;
    logic              emit;
    logic [CNT_W:0]    cnt_inc;

    assign advance = in_vld_reg && (!out_vld_reg || coeff.ready);
    assign src.ready = !in_vld_reg || advance;

    assign wide  = (cfg.sample_bits == SAMPLE_BITS_WIDE);
    assign width = wide ? FILL_W'(13) : FILL_W'(12);
    assign target = (32'(cfg.wanted_count) > MAX_COUNT) ? CNT_W'(MAX_COUNT)
                                                         : CNT_W'(cfg.wanted_count);

    always_comb
    begin
        cnt0  = poly_mark_reg ? '0 : cnt_reg;
        res0  = (poly_mark_reg || buf_mark_reg) ? '0 : res_reg;
        fill0 = (poly_mark_reg || buf_mark_reg) ? '0 : fill_reg;
        done  = (cnt0 >= target);
        res1  = res0 | (RES_W'(byte_reg) << fill0[3:0]);
        fill1 = fill0 + FILL_W'(8);
        take  = (fill1 >= width);
        cand  = wide ? res1[COEF_W-1:0] : {1'b0, res1[COEF_W-2:0]};
        emit  = !done && take && ({1'b0, cand} < cfg.modulus);
        cnt_inc = {1'b0, cnt0} + 1'b1;

        if (done)
        begin
            res_next  = res0;
            fill_next = fill0;
        end
        else if (take)
        begin
            res_next  = res1 >> width;
            fill_next = fill1 - width;
        end
        else
        begin
            res_next  = res1;
            fill_next = fill1;
        end
        cnt_next = emit ? cnt_inc[CNT_W-1:0] : cnt0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            res_reg     <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (src.valid && src.ready)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
            begin
                res_reg     <= res_next;
                fill_reg    <= fill_next;
                cnt_reg     <= cnt_next;
                out_vld_reg <= emit;
            end
            else if (coeff.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            byte_reg      <= src.data_byte;
            buf_mark_reg  <= src.new_buffer;
            poly_mark_reg <= src.new_poly;
        end
        if (advance && emit)
        begin
            coef_reg <= cand;
            idx_reg  <= IDX_W'(32'(cnt0));
            last_reg <= (cnt_inc == {1'b0, target});
        end
    end

    assign coeff.valid       = out_vld_reg;
    assign coeff.coefficient = coef_reg;
    assign coeff.coeff_index = idx_reg;
    assign coeff.last        = last_reg;

    // The reservoir never holds more than twelve bits between requests.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FILL_MAX)
        else $error("reservoir fill above limit");

    // A stalled result freezes the sampler state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !coeff.ready) |=> ($stable(cnt_reg) && $stable(fill_reg)))
        else $error("sampler state moved during output stall");

    // Every accepted candidate lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> out_vld_reg)
        else $error("accepted candidate lost");

endmodule

### rtl/core/lattice_rejection_sampler_top.sv
`timescale 1ns / 1ps
// An accepted byte is held in the input register; a coefficient it yields then goes to the result register.
// Throughput: one byte per cycle while the coefficient channel is not stalled, at most one coefficient per byte.
// The input register and the result register decouple the two channels.
// Reset clears the reservoir, the fill, the coefficient count and all valid flags,
// and loads the configuration registers with 12 bits, 3329 and 256.
module lattice_rejection_sampler_top #(
    parameter int MAX_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    lrs_cfg_if.sink     cfg,
    lrs_byte_if.sink    src,
    lrs_coeff_if.source coeff
);
    import lrs_pkg::*;

    cfg_t cfg_val;

    lrs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    lrs_core #(
        .MAX_COUNT (MAX_COUNT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_val),
        .src   (src),
        .coeff (coeff)
    );

endmodule
